### rtl/core/depth_to_surface_normal_unit_defines.svh
// Assertion macros for the depth to surface normal unit.
`ifndef DEPTH_TO_SURFACE_NORMAL_UNIT_DEFINES_SVH
`define DEPTH_TO_SURFACE_NORMAL_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DTSN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dtsn assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DTSN_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dtsn assertion failed");

`endif

### rtl/core/dtsn_pkg.sv
// Shared types and constants of the depth to surface normal unit.
package dtsn_pkg;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		CFG_RADIUS = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_idx_t;

	localparam int CFG_DATA_BITS = 13;
	localparam int MAX_HEIGHT    = 4096;

	localparam logic [3:0]  RADIUS_RST = 4'd2;
	localparam logic [10:0] WIDTH_RST  = 11'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;

	// normalized vector magnitudes stay below 2^NORM_BITS
	localparam int NORM_BITS  = 20;
	localparam int SQ_BITS    = 2 * NORM_BITS;
	localparam int SUM_BITS   = SQ_BITS + 2;
	localparam int QUO_BITS   = 31;
	localparam int DIV_STEPS  = QUO_BITS;
	localparam int ROOT_BITS  = 32;
	localparam int SQRT_STEPS = 16;
	localparam int MAG_BITS   = 15;
	localparam logic [MAG_BITS-1:0] MAG_MAX = '1;
	localparam int MAG_LAT    = DIV_STEPS + SQRT_STEPS + 1;

	typedef struct packed {
		logic valid;
		logic neg_x;
		logic neg_y;
		logic last;
	} side_t;

endpackage

### rtl/core/dtsn_line_store.sv
// One copy of the depth line store: one write port, one registered read port.
module dtsn_line_store #(
	parameter int DEPTH  = 17408,
	parameter int A_BITS = 15,
	parameter int D_BITS = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [A_BITS-1:0] waddr,
	input  logic [D_BITS-1:0] wdata,
	input  logic              re,
	input  logic [A_BITS-1:0] raddr,
	output logic [D_BITS-1:0] rdata
);

	logic [D_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/dtsn_unit_mag.sv
// Pipelined unit component: isqrt(num * 2^30 / den), saturated to Q0.15.
module dtsn_unit_mag
	import dtsn_pkg::*;
(
	input  logic                clk,
	input  logic                en,
	input  logic [SQ_BITS-1:0]  num,
	input  logic [SUM_BITS-1:0] den,
	output logic [MAG_BITS-1:0] mag
);

	logic [SUM_BITS-1:0]  rem_q [DIV_STEPS];
	logic [SUM_BITS-1:0]  den_q [DIV_STEPS];
	logic [QUO_BITS-1:0]  quo_q [DIV_STEPS];
	logic [ROOT_BITS-1:0] v_q   [SQRT_STEPS];
	logic [ROOT_BITS-1:0] res_q [SQRT_STEPS];
	logic [MAG_BITS-1:0]  mag_q;

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [SUM_BITS:0]   sh;
		logic [SUM_BITS-1:0] dv;
		logic [QUO_BITS-1:0] qin;
		logic                ge;
		if (k == 0) begin : g_first
			assign sh  = {1'b0, SUM_BITS'(num)};
			assign dv  = den;
			assign qin = '0;
		end else begin : g_next
			assign sh  = {rem_q[k-1], 1'b0};
			assign dv  = den_q[k-1];
			assign qin = quo_q[k-1];
		end
		assign ge = sh >= {1'b0, dv};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? SUM_BITS'(sh - {1'b0, dv}) : SUM_BITS'(sh);
				den_q[k] <= dv;
				quo_q[k] <= {qin[QUO_BITS-2:0], ge};
			end
		end
	end

	// digit-by-digit square root, one result bit per stage
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [ROOT_BITS-1:0] BIT = ROOT_BITS'(1) << (QUO_BITS - 1 - 2 * j);
		logic [ROOT_BITS-1:0] vin;
		logic [ROOT_BITS-1:0] rin;
		logic [ROOT_BITS-1:0] trial;
		if (j == 0) begin : g_first
			assign vin = ROOT_BITS'(quo_q[DIV_STEPS-1]);
			assign rin = '0;
		end else begin : g_next
			assign vin = v_q[j-1];
			assign rin = res_q[j-1];
		end
		assign trial = rin + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (vin >= trial) begin
					v_q[j]   <= vin - trial;
					res_q[j] <= (rin >> 1) + BIT;
				end else begin
					v_q[j]   <= vin;
					res_q[j] <= rin >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= (res_q[SQRT_STEPS-1] > ROOT_BITS'(MAG_MAX)) ? MAG_MAX
				: res_q[SQRT_STEPS-1][MAG_BITS-1:0];
		end
	end

	assign mag = mag_q;

endmodule

### rtl/core/depth_to_surface_normal_unit.sv
// Depth to surface normal unit: streaming central-difference normals from a depth frame.
//
// Input channel (in_valid / in_stall): one transaction per depth pixel in raster order
// (opcode OP_PIXEL) or a drain tick (OP_DRAIN) that flushes one pending result.
// Output channel (out_valid / out_stall): normal_x, normal_y (signed Q1.15), normal_z
// (Q0.15) and last_of_frame on the final pixel of the frame.
// Config channel (cfg_valid / cfg_ready): radius, image_width, image_height; any write to one
// of these restarts the frame. Write only while the pipeline is empty.
// Throughput: one transaction per cycle while in_stall is low. A result is emitted when the
// input that completes its taps (radius*width+radius pixels later) is accepted; most of the
// pipeline depth lies in the 31-stage divider and 16-stage square root in each component unit.
// The line store is four copies of one memory so that all four taps read in the same cycle.
// Reset restores the default registers and empties the pipeline; the input is held off
// until the first clock edge after reset and in the cycle after each config write.
// A stalled output freezes the whole pipeline and holds off the input; nothing is lost.
`include "depth_to_surface_normal_unit_defines.svh"

module depth_to_surface_normal_unit
	import dtsn_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 8,
	parameter int DEPTH_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [DEPTH_BITS-1:0]    depth,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [15:0]       normal_x,
	output logic signed [15:0]       normal_y,
	output logic [MAG_BITS-1:0]      normal_z,
	output logic                     last_of_frame,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int LINE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
	localparam int A_BITS   = $clog2(LINE_DEPTH);
	localparam int A1_BITS  = A_BITS + 1;
	localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
	localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
	localparam int R_BITS   = $clog2(MAX_RADIUS + 1);
	localparam int IDX_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int SP_BITS  = $clog2(2 * MAX_RADIUS + 1);
	localparam int P_BITS   = DEPTH_BITS + SP_BITS;
	localparam int SH_BITS  = $clog2(P_BITS + 1);

	// configuration
	logic [3:0]  radius_q;
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic        cfg_busy_q;
	logic        cfg_acc, cfg_hit;
	logic [R_BITS-1:0]   r_c;
	logic [W_BITS-1:0]   w_c;
	logic [H_BITS-1:0]   h_c;
	logic [IDX_BITS-1:0] total_q, lag_q;

	// frame position
	logic [IDX_BITS-1:0] in_idx_q, out_idx_q, in_nxt;
	logic [A_BITS-1:0]   wptr_q, optr_q;
	logic [W_BITS-1:0]   ow_q, wrem;
	logic [H_BITS-1:0]   oh_q, hrem;
	logic [IDX_BITS:0]   need_sum;
	logic                en, in_acc, wr, emit, last_p;
	logic [R_BITS-1:0]   dl, dr, du, dd;

	// pipeline
	side_t               side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic [A_BITS-1:0]   optr_s1;
	logic [R_BITS-1:0]   dl_s1, dr_s1, du_s1, dd_s1;
	logic [A1_BITS-1:0]  optr_e, off_u, off_d, al_t, ar_t, au_t, ad_t;
	logic [A_BITS-1:0]   al, ar, au, ad;
	logic [SP_BITS-1:0]  ws_s2, hs_s2, ws_s3, hs_s3;
	logic [DEPTH_BITS-1:0] tl, tr, tu, td;
	logic [DEPTH_BITS:0] da, db;
	logic [DEPTH_BITS-1:0] mag_a_s3, mag_b_s3;
	logic [P_BITS-1:0]   x_s4, y_s4, z_s4, x_s5, y_s5, z_s5, or_xyz;
	logic [SH_BITS-1:0]  sh, sh_s5;
	logic [NORM_BITS-1:0] xs_s6, ys_s6, zs_s6;
	logic [SQ_BITS-1:0]  x2_s7, y2_s7, z2_s7, x2_s8, y2_s8, z2_s8;
	logic [SUM_BITS-1:0] s_s8;
	logic [MAG_BITS-1:0] mag_x, mag_y, mag_z;
	side_t               side_dl [MAG_LAT];

	logic                out_valid_q, last_q;
	logic [15:0]         nx_q, ny_q;
	logic [MAG_BITS-1:0] nz_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_acc && (cfg_index == CFG_RADIUS || cfg_index == CFG_WIDTH
		|| cfg_index == CFG_HEIGHT);

	always_comb begin
		if (radius_q == 4'd0) begin
			r_c = R_BITS'(1);
		end else if (32'(radius_q) > MAX_RADIUS) begin
			r_c = R_BITS'(MAX_RADIUS);
		end else begin
			r_c = R_BITS'(radius_q);
		end
		if (width_q < 11'd2) begin
			w_c = W_BITS'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_c = W_BITS'(MAX_WIDTH);
		end else begin
			w_c = W_BITS'(width_q);
		end
		if (height_q < 13'd2) begin
			h_c = H_BITS'(2);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_c = H_BITS'(MAX_HEIGHT);
		end else begin
			h_c = H_BITS'(height_q);
		end
	end

	// frame size and lag, valid in the cycle after any register change
	always_ff @(posedge clk) begin
		total_q <= IDX_BITS'(w_c) * IDX_BITS'(h_c);
		lag_q   <= IDX_BITS'(r_c) * IDX_BITS'(w_c) + IDX_BITS'(r_c);
	end

	// ---------------- front end ----------------
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en || cfg_busy_q;
	assign in_acc   = in_valid && !in_stall;
	assign wr       = in_acc && opcode == OP_PIXEL && in_idx_q < total_q;
	assign in_nxt   = in_idx_q + IDX_BITS'(wr);
	assign need_sum = {1'b0, out_idx_q} + {1'b0, lag_q};
	assign emit     = in_acc && (in_nxt == total_q || {1'b0, in_nxt} > need_sum);
	assign last_p   = out_idx_q == total_q - IDX_BITS'(1);
	assign wrem     = w_c - W_BITS'(1) - ow_q;
	assign hrem     = h_c - H_BITS'(1) - oh_q;

	// clamped tap distances to each side
	always_comb begin
		dl = (32'(ow_q) < 32'(r_c)) ? R_BITS'(ow_q) : r_c;
		dr = (32'(wrem) < 32'(r_c)) ? R_BITS'(wrem) : r_c;
		du = (32'(oh_q) < 32'(r_c)) ? R_BITS'(oh_q) : r_c;
		dd = (32'(hrem) < 32'(r_c)) ? R_BITS'(hrem) : r_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= RADIUS_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			cfg_busy_q <= 1'b1;
			in_idx_q   <= '0;
			out_idx_q  <= '0;
			wptr_q     <= '0;
			optr_q     <= '0;
			ow_q       <= '0;
			oh_q       <= '0;
		end else begin
			cfg_busy_q <= cfg_acc;
			if (cfg_hit) begin
				case (cfg_idx_t'(cfg_index))
					CFG_RADIUS: radius_q <= cfg_data[3:0];
					CFG_WIDTH:  width_q  <= cfg_data[10:0];
					CFG_HEIGHT: height_q <= cfg_data[12:0];
					default:    radius_q <= radius_q;
				endcase
				in_idx_q  <= '0;
				out_idx_q <= '0;
				wptr_q    <= '0;
				optr_q    <= '0;
				ow_q      <= '0;
				oh_q      <= '0;
			end else if (emit && last_p) begin
				in_idx_q  <= '0;
				out_idx_q <= '0;
				wptr_q    <= '0;
				optr_q    <= '0;
				ow_q      <= '0;
				oh_q      <= '0;
			end else begin
				if (wr) begin
					in_idx_q <= in_nxt;
					wptr_q   <= (wptr_q == A_BITS'(LINE_DEPTH - 1)) ? '0 : wptr_q + A_BITS'(1);
				end
				if (emit) begin
					out_idx_q <= out_idx_q + IDX_BITS'(1);
					optr_q    <= (optr_q == A_BITS'(LINE_DEPTH - 1)) ? '0 : optr_q + A_BITS'(1);
					if (ow_q == w_c - W_BITS'(1)) begin
						ow_q <= '0;
						oh_q <= oh_q + H_BITS'(1);
					end else begin
						ow_q <= ow_q + W_BITS'(1);
					end
				end
			end
		end
	end

	// ---------------- s1: tap addresses ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1 <= '{valid: emit, neg_x: 1'b0, neg_y: 1'b0, last: last_p};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			optr_s1 <= optr_q;
			dl_s1   <= dl;
			dr_s1   <= dr;
			du_s1   <= du;
			dd_s1   <= dd;
		end
	end

	assign optr_e = {1'b0, optr_s1};
	assign off_u  = A1_BITS'(du_s1) * A1_BITS'(w_c);
	assign off_d  = A1_BITS'(dd_s1) * A1_BITS'(w_c);

	// circular address arithmetic, one wrap at most
	always_comb begin
		al_t = optr_e + ((optr_e < A1_BITS'(dl_s1)) ? A1_BITS'(LINE_DEPTH) : '0)
			- A1_BITS'(dl_s1);
		au_t = optr_e + ((optr_e < off_u) ? A1_BITS'(LINE_DEPTH) : '0) - off_u;
		ar_t = optr_e + A1_BITS'(dr_s1);
		ad_t = optr_e + off_d;
		if (ar_t >= A1_BITS'(LINE_DEPTH)) begin
			ar_t = ar_t - A1_BITS'(LINE_DEPTH);
		end
		if (ad_t >= A1_BITS'(LINE_DEPTH)) begin
			ad_t = ad_t - A1_BITS'(LINE_DEPTH);
		end
		al = al_t[A_BITS-1:0];
		ar = ar_t[A_BITS-1:0];
		au = au_t[A_BITS-1:0];
		ad = ad_t[A_BITS-1:0];
	end

	dtsn_line_store #(.DEPTH(LINE_DEPTH), .A_BITS(A_BITS), .D_BITS(DEPTH_BITS)) u_store_l (
		.clk(clk), .we(wr), .waddr(wptr_q), .wdata(depth), .re(en), .raddr(al), .rdata(tl)
	);
	dtsn_line_store #(.DEPTH(LINE_DEPTH), .A_BITS(A_BITS), .D_BITS(DEPTH_BITS)) u_store_r (
		.clk(clk), .we(wr), .waddr(wptr_q), .wdata(depth), .re(en), .raddr(ar), .rdata(tr)
	);
	dtsn_line_store #(.DEPTH(LINE_DEPTH), .A_BITS(A_BITS), .D_BITS(DEPTH_BITS)) u_store_u (
		.clk(clk), .we(wr), .waddr(wptr_q), .wdata(depth), .re(en), .raddr(au), .rdata(tu)
	);
	dtsn_line_store #(.DEPTH(LINE_DEPTH), .A_BITS(A_BITS), .D_BITS(DEPTH_BITS)) u_store_d (
		.clk(clk), .we(wr), .waddr(wptr_q), .wdata(depth), .re(en), .raddr(ad), .rdata(td)
	);

	// ---------------- s2: taps arrive, differences ----------------
	assign da = {1'b0, tl} - {1'b0, tr};
	assign db = {1'b0, tu} - {1'b0, td};

	// ---------------- pipeline registers s2..s8 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
			side_s7 <= '0;
			side_s8 <= '0;
		end else if (en) begin
			side_s2 <= side_s1;
			side_s3 <= '{valid: side_s2.valid, neg_x: da[DEPTH_BITS], neg_y: db[DEPTH_BITS],
				last: side_s2.last};
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			side_s8 <= side_s7;
		end
	end

	// highest set bit at or above NORM_BITS sets the common right shift
	always_comb begin
		or_xyz = x_s4 | y_s4 | z_s4;
		sh     = '0;
		for (int i = NORM_BITS; i < P_BITS; i++) begin
			if (or_xyz[i]) begin
				sh = SH_BITS'(i - NORM_BITS + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ws_s2    <= SP_BITS'(dl_s1) + SP_BITS'(dr_s1);
			hs_s2    <= SP_BITS'(du_s1) + SP_BITS'(dd_s1);
			ws_s3    <= ws_s2;
			hs_s3    <= hs_s2;
			mag_a_s3 <= da[DEPTH_BITS] ? DEPTH_BITS'(-da) : da[DEPTH_BITS-1:0];
			mag_b_s3 <= db[DEPTH_BITS] ? DEPTH_BITS'(-db) : db[DEPTH_BITS-1:0];
			x_s4     <= P_BITS'(mag_a_s3) * P_BITS'(hs_s3);
			y_s4     <= P_BITS'(mag_b_s3) * P_BITS'(ws_s3);
			z_s4     <= P_BITS'(ws_s3) * P_BITS'(hs_s3);
			x_s5     <= x_s4;
			y_s5     <= y_s4;
			z_s5     <= z_s4;
			sh_s5    <= sh;
			xs_s6    <= NORM_BITS'(x_s5 >> sh_s5);
			ys_s6    <= NORM_BITS'(y_s5 >> sh_s5);
			zs_s6    <= NORM_BITS'(z_s5 >> sh_s5);
			x2_s7    <= SQ_BITS'(xs_s6) * SQ_BITS'(xs_s6);
			y2_s7    <= SQ_BITS'(ys_s6) * SQ_BITS'(ys_s6);
			z2_s7    <= SQ_BITS'(zs_s6) * SQ_BITS'(zs_s6);
			x2_s8    <= x2_s7;
			y2_s8    <= y2_s7;
			z2_s8    <= z2_s7;
			s_s8     <= SUM_BITS'(x2_s7) + SUM_BITS'(y2_s7) + SUM_BITS'(z2_s7);
		end
	end

	// ---------------- component units ----------------
	dtsn_unit_mag u_mag_x (.clk(clk), .en(en), .num(x2_s8), .den(s_s8), .mag(mag_x));
	dtsn_unit_mag u_mag_y (.clk(clk), .en(en), .num(y2_s8), .den(s_s8), .mag(mag_y));
	dtsn_unit_mag u_mag_z (.clk(clk), .en(en), .num(z2_s8), .den(s_s8), .mag(mag_z));

	// sideband follows the units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAG_LAT; i++) begin
				side_dl[i] <= '0;
			end
		end else if (en) begin
			side_dl[0] <= side_s8;
			for (int i = 1; i < MAG_LAT; i++) begin
				side_dl[i] <= side_dl[i-1];
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_dl[MAG_LAT-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_q   <= side_dl[MAG_LAT-1].neg_x ? 16'(-{1'b0, mag_x}) : {1'b0, mag_x};
			ny_q   <= side_dl[MAG_LAT-1].neg_y ? 16'(-{1'b0, mag_y}) : {1'b0, mag_y};
			nz_q   <= mag_z;
			last_q <= side_dl[MAG_LAT-1].last;
		end
	end

	assign out_valid     = out_valid_q;
	assign normal_x      = nx_q;
	assign normal_y      = ny_q;
	assign normal_z      = nz_q;
	assign last_of_frame = last_q;

	// ---------------- assertions ----------------
	`DTSN_ASSERT_IMP(a_out_le_in, 1'b1, out_idx_q <= in_idx_q)
	`DTSN_ASSERT_IMP(a_hold_input, out_valid_q && out_stall, in_stall)
	`DTSN_ASSERT_NXT(a_cfg_restart, cfg_hit, in_idx_q == '0 && out_idx_q == '0 && in_stall)
	`DTSN_ASSERT_NXT(a_emit_enters, emit, side_s1.valid)

endmodule

### bench/depth_to_surface_normal_unit_test.sv
// Self-checking testbench for the depth to surface normal unit.
`timescale 1ns / 1ps

module depth_to_surface_normal_unit_test;
	import dtsn_pkg::*;

	localparam int LINE_WORDS = 17 * 1024;
	localparam int ITEM_GOAL  = 1850;
	localparam int DRAIN_WAIT = 80;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic [14:0]        nz;
		logic               last;
	} normal_t;

	typedef struct packed {
		logic    op;
		logic [15:0] d;
		logic    lit;
		normal_t val;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_PIXEL;
	logic [15:0] depth = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] normal_x, normal_y;
	logic [14:0] normal_z;
	logic last_of_frame;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_RADIUS;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	depth_to_surface_normal_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .depth(depth),
		.out_valid(out_valid), .out_stall(out_stall),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.last_of_frame(last_of_frame),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [15:0] depth_rows [LINE_WORDS];
	int unsigned pix_in, pix_out;
	logic [3:0]  rad_reg = RADIUS_RST;
	logic [10:0] wid_reg = WIDTH_RST;
	logic [12:0] hgt_reg = HEIGHT_RST;

	normal_t normal_q[$];
	int errors = 0, items = 0, checked = 0, frames = 0, cfg_writes = 0;
	longint cycles = 0;
	bit quiet = 0;
	bit hold_req = 0;
	int hold_left = 0, rx_gap = 0;

	function automatic int unsigned clampi(int unsigned v, int unsigned lo, int unsigned hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [14:0] unit_q15(longint unsigned m, longint unsigned s);
		logic [127:0] num;
		longint unsigned q, root;
		num = m * m;
		num = (num << 30) / s;
		q = (num > (128'd1 << 30)) ? (64'd1 << 30) : num[63:0];
		root = 0;
		for (int b = 15; b >= 0; b--)
			if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= q)
				root = root | (64'd1 << b);
		if (q >= 64'd1 << 30) root = 32768;
		return root > 32767 ? 15'h7fff : root[14:0];
	endfunction

	function automatic void cfg_apply(logic [1:0] idx, logic [12:0] v);
		case (idx)
			CFG_RADIUS: rad_reg = v[3:0];
			CFG_WIDTH:  wid_reg = v[10:0];
			CFG_HEIGHT: hgt_reg = v;
			default: return;
		endcase
		pix_in = 0;
		pix_out = 0;
	endfunction

	function automatic bit normal_step(logic op, logic [15:0] d, output normal_t res);
		int unsigned r, w_, h_, total, p, need, row, col, wl, wr, hu, hd, ws, hs;
		longint a, b;
		longint unsigned x, y, z, s;
		logic [14:0] mx, my;
		r = clampi(rad_reg, 1, 8);
		w_ = clampi(wid_reg, 2, 1024);
		h_ = clampi(hgt_reg, 2, MAX_HEIGHT);
		total = w_ * h_;
		res = '0;
		if (op == OP_PIXEL && pix_in < total) begin
			depth_rows[pix_in % LINE_WORDS] = d;
			pix_in++;
		end
		if (pix_out >= total) return 0;
		p = pix_out;
		need = p + r * w_ + r;
		if (need > total - 1) need = total - 1;
		if (pix_in <= need) return 0;
		row = p / w_;
		col = p % w_;
		wl = col > r ? col - r : 0;
		wr = (col + r > w_ - 1) ? w_ - 1 : col + r;
		hu = row > r ? row - r : 0;
		hd = (row + r > h_ - 1) ? h_ - 1 : row + r;
		ws = wr - wl;
		hs = hd - hu;
		a = longint'(depth_rows[(row * w_ + wl) % LINE_WORDS])
			- longint'(depth_rows[(row * w_ + wr) % LINE_WORDS]);
		b = longint'(depth_rows[(hu * w_ + col) % LINE_WORDS])
			- longint'(depth_rows[(hd * w_ + col) % LINE_WORDS]);
		x = (a < 0 ? -a : a) * hs;
		y = (b < 0 ? -b : b) * ws;
		z = ws * hs;
		while (((x | y | z) >> 20) != 0) begin
			x >>= 1; y >>= 1; z >>= 1;
		end
		s = x * x + y * y + z * z;
		mx = unit_q15(x, s);
		my = unit_q15(y, s);
		res.nx = a < 0 ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
		res.ny = b < 0 ? -$signed({1'b0, my}) : $signed({1'b0, my});
		res.nz = unit_q15(z, s);
		res.last = (p == total - 1);
		pix_out++;
		if (pix_out >= total) begin
			pix_out = 0;
			pix_in = 0;
		end
		return 1;
	endfunction

	// one input transaction; the expectation is queued at acceptance
	task automatic push(logic op, logic [15:0] d, logic lit = 0, normal_t lv = '0);
		normal_t nv;
		in_valid <= 1'b1;
		opcode <= op;
		depth <= d;
		do @(posedge clk); while (in_stall);
		if (normal_step(op, d, nv)) normal_q.push_back(lit ? lv : nv);
		items++;
	endtask

	task automatic pace();
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// waits for an empty pipeline, then writes all registers back to back, and the unused index if spare
	task automatic configure(logic [12:0] rv, logic [12:0] wv, logic [12:0] hv, bit spare = 0);
		logic [12:0] vals [4];
		vals = '{rv, wv, hv, 13'($urandom_range(0, 8191))};
		in_valid <= 1'b0;
		wait (normal_q.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		for (int i = 0; i < (spare ? 4 : 3); i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			cfg_apply(2'(i), vals[i]);
			cfg_writes++;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_depth(int mode, logic [15:0] base);
		case (mode)
			0: return 16'($urandom);
			1: return base + 16'($urandom_range(0, 63)) - 16'd32;
			default: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
		endcase
	endfunction

	// receiver side: random stall bursts plus one long hold-off on request; also ends the run at the cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("depth_to_surface_normal_unit_test: done, errors");
			$finish;
		end
		if (hold_req) begin
			hold_req = 0;
			hold_left = 200;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			rx_gap = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		normal_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (normal_q.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				e = normal_q.pop_front();
				checked++;
				if (normal_x !== e.nx) begin
					$error("normal_x expected %0d got %0d", e.nx, normal_x); errors++;
				end
				if (normal_y !== e.ny) begin
					$error("normal_y expected %0d got %0d", e.ny, normal_y); errors++;
				end
				if (normal_z !== e.nz) begin
					$error("normal_z expected %0d got %0d", e.nz, normal_z); errors++;
				end
				if (last_of_frame !== e.last) begin
					$error("last_of_frame expected %0b got %0b", e.last, last_of_frame);
					errors++;
				end
			end
		end
	end

	localparam normal_t FLAT = '{nx: 16'sd0, ny: 16'sd0, nz: 15'd32767, last: 1'b0};
	localparam normal_t FLAT_LAST = '{nx: 16'sd0, ny: 16'sd0, nz: 15'd32767, last: 1'b1};

	// 2x2 frames at radius 1: flat, then two extreme checkerboards
	stim_row_t dir_tab [23] = '{
		'{OP_DRAIN, 16'h0000, 1'b0, '0},
		'{OP_PIXEL, 16'h1234, 1'b0, '0},
		'{OP_PIXEL, 16'h1234, 1'b0, '0},
		'{OP_PIXEL, 16'h1234, 1'b0, '0},
		'{OP_PIXEL, 16'h1234, 1'b1, FLAT},
		'{OP_PIXEL, 16'h0000, 1'b1, FLAT},      // dropped pixel acts as a drain
		'{OP_DRAIN, 16'h0000, 1'b1, FLAT},
		'{OP_DRAIN, 16'h0000, 1'b1, FLAT_LAST},
		'{OP_DRAIN, 16'h0000, 1'b0, '0},        // nothing ready
		'{OP_PIXEL, 16'h0000, 1'b0, '0},
		'{OP_PIXEL, 16'hffff, 1'b0, '0},
		'{OP_PIXEL, 16'hffff, 1'b0, '0},
		'{OP_PIXEL, 16'h0000, 1'b0, '0},
		'{OP_DRAIN, 16'hffff, 1'b0, '0},
		'{OP_DRAIN, 16'h0000, 1'b0, '0},
		'{OP_DRAIN, 16'hffff, 1'b0, '0},
		'{OP_PIXEL, 16'hffff, 1'b0, '0},
		'{OP_PIXEL, 16'h0000, 1'b0, '0},
		'{OP_PIXEL, 16'h0000, 1'b0, '0},
		'{OP_PIXEL, 16'hffff, 1'b0, '0},
		'{OP_DRAIN, 16'h0000, 1'b0, '0},
		'{OP_DRAIN, 16'h0000, 1'b0, '0},
		'{OP_DRAIN, 16'h0000, 1'b0, '0}
	};

	initial begin
		int unsigned w_, h_, total, n;
		int mode;
		logic [15:0] base;
		bit held = 0, paused = 0;
		for (int i = 0; i < LINE_WORDS; i++) depth_rows[i] = '0;
		pix_in = 0;
		pix_out = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a few pixels into the default 640x480 frame, then restart
		repeat (5) push(OP_PIXEL, 16'($urandom));
		configure(13'd1, 13'd2, 13'd2);
		foreach (dir_tab[i]) begin
			push(dir_tab[i].op, dir_tab[i].d, dir_tab[i].lit, dir_tab[i].val);
			pace();
		end
		frames += 3;

		for (int k = 0; items < ITEM_GOAL; k++) begin
			case (k)
				0: configure(13'd3, 13'd64, 13'd8);
				1: configure(13'd1, 13'd2, 13'd4096, 1);
				2: configure(13'd8, 13'd2, 13'd2);
				3: configure(13'd0, 13'd1, 13'd0);      // below range, clamped up
				4: configure(13'd15, 13'd2047, 13'd8191);
				default:
					if ($urandom_range(0, 7) == 0)
						configure(13'($urandom), 13'($urandom), 13'($urandom), 1);
					else if ($urandom_range(0, 3) == 0)
						configure(13'($urandom_range(1, 8)), 13'($urandom_range(2, 24)),
							13'($urandom_range(2, 10)));
					else
						configure(13'($urandom_range(1, 3)), 13'($urandom_range(2, 24)),
							13'($urandom_range(2, 10)));
			endcase
			w_ = clampi(wid_reg, 2, 1024);
			h_ = clampi(hgt_reg, 2, MAX_HEIGHT);
			total = w_ * h_;
			mode = $urandom_range(0, 2);
			base = 16'($urandom);
			if (items >= ITEM_GOAL - 150) quiet = 1;
			if (total > 2100) begin
				// frame too large to run: a partial frame, then restart
				n = $urandom_range(1, 60);
				repeat (n) begin
					push(OP_PIXEL, pick_depth(mode, base));
					pace();
				end
				continue;
			end
			for (int i = 0; i < total; i++) begin
				if ($urandom_range(0, 9) == 0) push(OP_DRAIN, 16'($urandom));
				if (k == 0 && i == 300 && !held) begin
					hold_req = 1;
					held = 1;
				end
				if (k >= 6 && i == total / 2 && !paused) begin
					in_valid <= 1'b0;
					wait (normal_q.size() == 0);
					@(posedge clk);
					paused = 1;
				end
				if (mode == 1) base = pick_depth(1, base);
				push(OP_PIXEL, pick_depth(mode, base));
				pace();
			end
			if ($urandom_range(0, 3) == 0) push(OP_PIXEL, 16'($urandom));
			while (pix_in != 0 || pix_out != 0) begin
				push(OP_DRAIN, 16'($urandom));
				pace();
			end
			if ($urandom_range(0, 3) == 0) push(OP_DRAIN, 16'($urandom));
			frames++;
		end

		in_valid <= 1'b0;
		wait (normal_q.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d input transactions, %0d results checked, %0d frames,",
			items, checked, frames);
		$display("%0d register writes including clamped and out of range settings", cfg_writes);
		if (errors == 0)
			$display("depth_to_surface_normal_unit_test: done, clean");
		else
			$display("depth_to_surface_normal_unit_test: done, errors");
		$finish;
	end

endmodule
